// ===== rtl/nee_pkg.sv =====
// shared constants, types and character helpers of the name escape encoder
`default_nettype none
package nee_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned MaxRes  = 5;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // signature modes
  localparam logic [ModeW-1:0] MODE_NONE   = 2'd0;
  localparam logic [ModeW-1:0] MODE_STRAIN = 2'd1;
  localparam logic [ModeW-1:0] MODE_TABLE  = 2'd2;

  // register addresses
  localparam logic [AddrW-1:0] ADDR_SIG_MODE = 3'd0;

  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_UNDER   = 8'h5F;
  localparam logic [CharW-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CharW-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CharW-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CharW-1:0] CH_DOT     = 8'h2E;
  localparam logic [CharW-1:0] CH_PERCENT = 8'h25;
  localparam logic [CharW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CharW-1:0] CH_TILDE   = 8'h7E;
  localparam logic [CharW-1:0] CH_BANG    = 8'h21;
  localparam logic [CharW-1:0] CH_AT      = 8'h40;
  localparam logic [CharW-1:0] CH_LOW_B   = 8'h62;
  localparam logic [CharW-1:0] CH_NUL     = 8'h00;

  typedef logic [MaxRes-1:0][CharW-1:0] res_bytes_t;

  // expanded form of one input transaction
  typedef struct packed {
    res_bytes_t      bytes;
    logic [CntW-1:0] cnt;
    logic            valid_char;
    logic            last;
    logic            changed;
  } nee_exp_t;

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] v);
    logic [CharW-1:0] r;
    if (v < 4'd10) r = 8'h30 + {4'd0, v};
    else           r = 8'h41 + {4'd0, v} - 8'd10;
    return r;
  endfunction

  function automatic logic always_escaped(input logic [CharW-1:0] c);
    logic r;
    case (c)
      8'h25, 8'h3A, 8'h24, 8'h3F, 8'h22, 8'h27, 8'h60,
      8'h3B, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h23, 8'h7C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/nee_expand.sv =====
// expands one name byte into its escaped result bytes and signature
`default_nettype none
module nee_expand (
  input  wire logic [nee_pkg::CharW-1:0] char_i,
  input  wire logic                      last_i,
  input  wire logic [nee_pkg::ModeW-1:0] mode_i,
  input  wire logic                      flag_i,
  output nee_pkg::nee_exp_t              exp_o
);
  import nee_pkg::*;

  res_bytes_t       base;
  logic [CntW-1:0]  nb;
  logic             chg;
  logic             esc;
  logic             sig;
  logic [CharW-1:0] sig_ch;

  always_comb begin
    base = '0;
    nb   = '0;
    chg  = 1'b1;
    esc  = always_escaped(char_i) ||
           (((char_i == CH_SLASH) || (char_i == CH_TILDE)) && (mode_i == MODE_TABLE));
    if (char_i == CH_SPACE) begin
      base[0] = CH_UNDER;
      nb      = 3'd1;
    end else if ((char_i == CH_LPAREN) || (char_i == CH_RPAREN)) begin
      nb = 3'd0;
    end else if (char_i == CH_COMMA) begin
      base[0] = CH_DOT;
      base[1] = CH_DOT;
      nb      = 3'd2;
    end else if (esc) begin
      base[0] = CH_PERCENT;
      base[1] = hex_digit(char_i[7:4]);
      base[2] = hex_digit(char_i[3:0]);
      nb      = 3'd3;
    end else begin
      base[0] = char_i;
      nb      = 3'd1;
      chg     = 1'b0;
    end
  end

  always_comb begin
    sig    = last_i && (flag_i || chg) &&
             ((mode_i == MODE_STRAIN) || (mode_i == MODE_TABLE));
    sig_ch = (mode_i == MODE_STRAIN) ? CH_BANG : CH_AT;
    exp_o  = '0;
    exp_o.last       = last_i;
    exp_o.changed    = chg;
    exp_o.valid_char = 1'b1;
    for (int k = 0; k < MaxRes; k++) begin
      if (CntW'(k) < nb)                   exp_o.bytes[k] = base[k];
      else if (sig && (CntW'(k) == nb))    exp_o.bytes[k] = sig_ch;
      else if (sig)                        exp_o.bytes[k] = CH_LOW_B;
      else                                 exp_o.bytes[k] = CH_NUL;
    end
    exp_o.cnt = sig ? (nb + 3'd2) : nb;
    // last byte with nothing to emit still closes the name
    if (last_i && !sig && (nb == 3'd0)) begin
      exp_o.cnt        = 3'd1;
      exp_o.valid_char = 1'b0;
      exp_o.bytes[0]   = CH_NUL;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nee_serialiser.sv =====
// holds one expanded transaction and drives it out a byte per cycle while out_ready allows
`default_nettype none
module nee_serialiser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load_i,
  input  wire nee_pkg::nee_exp_t         exp_i,
  output logic                           free_o,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [nee_pkg::CharW-1:0]      out_char,
  output logic                           out_valid_char,
  output logic                           out_last
);
  import nee_pkg::*;

  res_bytes_t       buf_r, buf_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             vchar_r, vchar_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] out_char_r, out_char_nxt;
  logic             out_vchar_r, out_vchar_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;
  logic             emit;

  always_comb begin
    out_load = !out_valid_r || out_ready;
    emit     = (cnt_r != '0) && out_load;
    free_o   = (cnt_r == '0) || ((cnt_r == 3'd1) && out_load);

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_vchar_nxt = out_vchar_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = buf_r[0];
      out_vchar_nxt = vchar_r;
      out_last_nxt  = last_r && (cnt_r == 3'd1);
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end

    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    vchar_nxt = vchar_r;
    last_nxt  = last_r;
    if (load_i) begin
      buf_nxt   = exp_i.bytes;
      cnt_nxt   = exp_i.cnt;
      vchar_nxt = exp_i.valid_char;
      last_nxt  = exp_i.last;
    end else if (emit) begin
      // shift the next byte to the head
      for (int k = 0; k < MaxRes - 1; k++) buf_nxt[k] = buf_r[k+1];
      buf_nxt[MaxRes-1] = CH_NUL;
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    buf_r       <= buf_nxt;
    vchar_r     <= vchar_nxt;
    last_r      <= last_nxt;
    out_char_r  <= out_char_nxt;
    out_vchar_r <= out_vchar_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_valid_char = out_vchar_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/name_escape_encoder_core.sv =====
// Name escape encoder: one name byte per input transaction, escaped bytes out one per cycle
// while out_ready does not stall them. An accepted byte sits in the input register, is
// expanded into zero to five result bytes (escape plus optional "!b"/"@b" signature on
// the last byte) and loaded into a serialising buffer that feeds the output register.
// The output register emits one result per cycle unless stalled; a hex escape gives three
// result bytes before any signature, and an item with no result still passes through the
// input register. A new byte is accepted every cycle while each item has at most one
// result and the output is not stalled; an item with more results holds the next byte in
// the input register until the buffer is down to its last result. The first result
// passes the input register, the serialising buffer and the output register in turn.
// signature_mode sits at byte address 0 of the configuration port and is read back there.
`default_nettype none
module name_escape_encoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [nee_pkg::CharW-1:0]  in_char,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [nee_pkg::CharW-1:0]       out_char,
  output logic                            out_valid_char,
  output logic                            out_last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nee_pkg::AddrW-1:0]  paddr,
  input  wire logic [nee_pkg::DataW-1:0]  pwdata,
  output logic [nee_pkg::DataW-1:0]       prdata,
  output logic                            pready
);
  import nee_pkg::*;

  logic             in_vld_r, in_vld_nxt;
  logic [CharW-1:0] in_char_r, in_char_nxt;
  logic             in_last_r, in_last_nxt;
  logic [ModeW-1:0] mode_r, mode_nxt;
  logic             flag_r, flag_nxt;
  logic             buf_free;
  logic             take;
  logic             in_acc;
  nee_exp_t         exp;

  nee_expand u_expand (
    .char_i (in_char_r),
    .last_i (in_last_r),
    .mode_i (mode_r),
    .flag_i (flag_r),
    .exp_o  (exp)
  );

  nee_serialiser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (take),
    .exp_i          (exp),
    .free_o         (buf_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_valid_char (out_valid_char),
    .out_last       (out_last)
  );

  always_comb begin
    take     = in_vld_r && buf_free;
    in_ready = !in_vld_r || buf_free;
    in_acc   = in_valid && in_ready;

    in_vld_nxt  = in_vld_r;
    in_char_nxt = in_char_r;
    in_last_nxt = in_last_r;
    if (in_acc) begin
      in_vld_nxt  = 1'b1;
      in_char_nxt = in_char;
      in_last_nxt = in_last;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end

    // sticky change flag, cleared once a name closes
    flag_nxt = flag_r;
    if (take) flag_nxt = in_last_r ? 1'b0 : (flag_r || exp.changed);

    mode_nxt = mode_r;
    if (psel && penable && pwrite && (paddr == ADDR_SIG_MODE)) mode_nxt = pwdata[ModeW-1:0];

    prdata = '0;
    if (paddr == ADDR_SIG_MODE) prdata = {{(DataW-ModeW){1'b0}}, mode_r};
    pready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      flag_r   <= 1'b0;
      mode_r   <= MODE_NONE;
    end else begin
      in_vld_r <= in_vld_nxt;
      flag_r   <= flag_nxt;
      mode_r   <= mode_nxt;
    end
    in_char_r <= in_char_nxt;
    in_last_r <= in_last_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/nee_checker.sv =====
// port-level checks on the name escape encoder, bound to the top level
`default_nettype none
module nee_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [nee_pkg::CharW-1:0] out_char,
  input wire logic                      out_valid_char,
  input wire logic                      out_last
);
  import nee_pkg::*;

  // end marker with no byte always closes the name and carries a zero byte
  a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_char |-> out_last && (out_char == CH_NUL))
    else $error("byte-less result not a closing marker");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_valid_char) &&
                                $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind name_escape_encoder_core nee_checker u_nee_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char       (out_char),
  .out_valid_char (out_valid_char),
  .out_last       (out_last)
);
`default_nettype wire
